/* rtl/thc_pkg.sv */
// Types, constants and digit helpers shared by the twelve-hour clock block.
`default_nettype none

package thc_pkg;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  // Item commands
  localparam logic CmdTick   = 1'b0;
  localparam logic CmdSample = 1'b1;

  // Register indexes, taken from paddr[2]
  localparam logic RegWindowLength   = 1'b0;
  localparam logic RegPressThreshold = 1'b1;

  localparam logic [7:0] WindowLengthRst   = 8'd30;
  localparam logic [7:0] PressThresholdRst = 8'd20;

  localparam logic [5:0] SecondRst = 6'd31;
  localparam logic [5:0] MinuteRst = 6'd52;
  localparam logic [3:0] HourRst   = 4'd2;
  localparam logic [6:0] DayRst    = 7'd15;

  localparam logic [5:0] SecondMax = 6'd59;
  localparam logic [5:0] MinuteMax = 6'd59;
  localparam logic [3:0] HourMax   = 4'd12;
  localparam logic [3:0] HourMin   = 4'd1;
  localparam logic [3:0] HourTen   = 4'd10;
  localparam logic [6:0] DayMax    = 7'd99;
  localparam logic [7:0] HitMax    = 8'd255;

  typedef struct packed {
    logic command;
    logic left_pressed;
    logic center_pressed;
    logic right_pressed;
  } thc_cmd_t;

  typedef struct packed {
    logic       hour_tens;
    logic [3:0] hour_ones;
    logic [2:0] minute_tens;
    logic [3:0] minute_ones;
    logic [5:0] second_value;
    logic [3:0] day_tens;
    logic [3:0] day_ones;
    logic       colon_on;
    logic       hour_leading_blank;
    logic       window_done;
  } thc_disp_t;

  typedef struct packed {
    logic [7:0] window_length;
    logic [7:0] press_threshold;
  } thc_cfg_t;

  // Tens digit of a value below 100: multiply by 205/2048
  function automatic logic [3:0] tens_of(input logic [6:0] v);
    logic [14:0] prod;
    prod = {8'b0, v} * 15'd205;
    return prod[14:11];
  endfunction

  function automatic logic [3:0] ones_of(input logic [6:0] v);
    logic [6:0] t10;
    t10 = {3'b0, tens_of(v)} * 7'd10;
    return 4'(v - t10);
  endfunction

endpackage

`default_nettype wire

/* rtl/thc_cmd_if.sv */
// Input channel carrying tick and button sample items.
`default_nettype none

interface thc_cmd_if;
  import thc_pkg::*;

  logic     valid;
  logic     ready;
  thc_cmd_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/thc_disp_if.sv */
// Output channel carrying display result items.
`default_nettype none

interface thc_disp_if;
  import thc_pkg::*;

  logic      valid;
  logic      ready;
  thc_disp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/thc_cfg.sv */
// APB register file for window length and press threshold.
`default_nettype none

module thc_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [thc_pkg::CfgAddrW-1:0]  paddr,
  input  logic [thc_pkg::CfgDataW-1:0]  pwdata,
  output logic [thc_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready,
  output thc_pkg::thc_cfg_t             cfg_o
);
  import thc_pkg::*;

  thc_cfg_t cfg_q;
  logic     wr_en;
  logic     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_length   <= WindowLengthRst;
      cfg_q.press_threshold <= PressThresholdRst;
    end else if (wr_en) begin
      case (reg_idx)
        RegWindowLength:   cfg_q.window_length   <= pwdata[7:0];
        RegPressThreshold: cfg_q.press_threshold <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegWindowLength:   prdata = {24'b0, cfg_q.window_length};
      RegPressThreshold: prdata = {24'b0, cfg_q.press_threshold};
      default:           prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* rtl/thc_core.sv */
// Clock and button-window state with its next-state update and digit split.
`default_nettype none

module thc_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  thc_pkg::thc_cmd_t  item_i,
  input  thc_pkg::thc_cfg_t  cfg_i,
  output thc_pkg::thc_disp_t result_o
);
  import thc_pkg::*;

  logic [5:0] sec_q, sec_d;
  logic [5:0] min_q, min_d;
  logic [3:0] hour_q, hour_d;
  logic [6:0] day_q, day_d;
  logic       colon_q, colon_d;
  logic [7:0] idx_q, idx_d;
  logic [7:0] lh_q, lh_d, ch_q, ch_d, rh_q, rh_d;
  logic [7:0] lh_bump, ch_bump, rh_bump;
  logic       done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_q   <= SecondRst;
      min_q   <= MinuteRst;
      hour_q  <= HourRst;
      day_q   <= DayRst;
      colon_q <= 1'b0;
      idx_q   <= '0;
      lh_q    <= '0;
      ch_q    <= '0;
      rh_q    <= '0;
    end else if (step_i) begin
      sec_q   <= sec_d;
      min_q   <= min_d;
      hour_q  <= hour_d;
      day_q   <= day_d;
      colon_q <= colon_d;
      idx_q   <= idx_d;
      lh_q    <= lh_d;
      ch_q    <= ch_d;
      rh_q    <= rh_d;
    end
  end

  // Saturating hit counts including this sample's levels
  assign lh_bump = (item_i.left_pressed   && lh_q != HitMax) ? lh_q + 8'd1 : lh_q;
  assign ch_bump = (item_i.center_pressed && ch_q != HitMax) ? ch_q + 8'd1 : ch_q;
  assign rh_bump = (item_i.right_pressed  && rh_q != HitMax) ? rh_q + 8'd1 : rh_q;

  always_comb begin
    sec_d   = sec_q;
    min_d   = min_q;
    hour_d  = hour_q;
    day_d   = day_q;
    colon_d = colon_q;
    idx_d   = idx_q;
    lh_d    = lh_q;
    ch_d    = ch_q;
    rh_d    = rh_q;
    done    = 1'b0;
    case (item_i.command)
      CmdTick: begin
        colon_d = ~colon_q;
        if (sec_q >= SecondMax) begin
          sec_d = '0;
          if (min_q >= MinuteMax) begin
            min_d = '0;
            if (hour_q >= HourMax) begin
              hour_d = HourMin;
              if (day_q < DayMax) day_d = day_q + 7'd1;
            end else begin
              hour_d = hour_q + 4'd1;
            end
          end else begin
            min_d = min_q + 6'd1;
          end
        end else begin
          sec_d = sec_q + 6'd1;
        end
      end
      CmdSample: begin
        if ({1'b0, idx_q} + 9'd1 < {1'b0, cfg_i.window_length}) begin
          idx_d = idx_q + 8'd1;
          lh_d  = lh_bump;
          ch_d  = ch_bump;
          rh_d  = rh_bump;
        end else begin
          // Close the window: apply each press, then clear the counts
          done  = 1'b1;
          idx_d = '0;
          lh_d  = '0;
          ch_d  = '0;
          rh_d  = '0;
          if (lh_bump > cfg_i.press_threshold)
            day_d = (day_q == 7'd0) ? DayMax : day_q - 7'd1;
          if (rh_bump > cfg_i.press_threshold)
            min_d = (min_q >= MinuteMax) ? 6'd0 : min_q + 6'd1;
          if (ch_bump > cfg_i.press_threshold)
            hour_d = (hour_q >= HourMax) ? HourMin : hour_q + 4'd1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    result_o.hour_leading_blank = (hour_d < HourTen);
    result_o.hour_tens          = !(hour_d < HourTen);
    result_o.hour_ones          = (hour_d < HourTen) ? hour_d : hour_d - HourTen;
    result_o.minute_tens        = 3'(tens_of({1'b0, min_d}));
    result_o.minute_ones        = ones_of({1'b0, min_d});
    result_o.second_value       = sec_d;
    result_o.day_tens           = tens_of(day_d);
    result_o.day_ones           = ones_of(day_d);
    result_o.colon_on           = colon_d;
    result_o.window_done        = done;
  end

  a_sec_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_q <= SecondMax) else $error("seconds out of range");
  a_min_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    min_q <= MinuteMax) else $error("minutes out of range");
  a_hour_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hour_q >= HourMin && hour_q <= HourMax) else $error("hours out of range");
  a_day_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    day_q <= DayMax) else $error("day count out of range");
  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(sec_q) && $stable(idx_q) && $stable(day_q))
    else $error("state moved without an item");

endmodule

`default_nettype wire

/* rtl/twelve_hour_clock_with_set_buttons.sv */
// Twelve-hour clock with set buttons: top level with input and result registers.
//
// Each accepted item (a clock tick or a button sample) yields exactly one
// result item showing hours, minutes, seconds, day count, colon and blanking
// after the update. The block accepts one item per cycle unless its held item
// waits behind a stalled sink; an accepted item waits in the input register,
// then moves to the result register, and the whole clock/window update sits
// combinationally between them. The input register refills whenever the
// result register is empty or being taken, so a stalled sink holds at most
// two items inside. The two configuration registers sit at byte addresses 0
// (window length) and 4 (press threshold) and must be written only while the
// block is idle.
`default_nettype none

module twelve_hour_clock_with_set_buttons (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  thc_cmd_if.sink                      in_i,
  thc_disp_if.source                   out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [thc_pkg::CfgAddrW-1:0] paddr,
  input  logic [thc_pkg::CfgDataW-1:0] pwdata,
  output logic [thc_pkg::CfgDataW-1:0] prdata,
  output logic                         pready
);
  import thc_pkg::*;

  thc_cfg_t  cfg;
  thc_cmd_t  item_q;
  logic      item_vld_q;
  thc_disp_t res_q, res_d;
  logic      res_vld_q;
  logic      step;
  logic      in_rdy;

  thc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  thc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (res_d)
  );

  // Advance the held item when the result slot is free or draining
  assign step   = item_vld_q && (!res_vld_q || out_o.ready);
  assign in_rdy = !item_vld_q || step;
  assign in_i.ready = in_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      if (in_rdy) item_vld_q <= in_i.valid;
      if (step) begin
        res_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_rdy && in_i.valid) item_q <= in_i.payload;
    if (step) res_q <= res_d;
  end

  assign out_o.valid   = res_vld_q;
  assign out_o.payload = res_q;

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q && !out_o.ready |=> res_vld_q) else $error("result dropped");
  a_step_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> res_vld_q) else $error("stepped item left no result");
  a_item_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_vld_q && !step |=> item_vld_q && $stable(item_q))
    else $error("held item lost");

endmodule

`default_nettype wire

/* bench/tb.sv */
// Testbench for the twelve-hour clock: drives ticks and button samples, predicts every display item.
`timescale 1ns / 100ps

module tb;
  import thc_pkg::*;

  localparam int unsigned WatchLimit  = 2000;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned ReportMax   = 10;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  thc_cmd_if  cmd_ch ();
  thc_disp_if disp_ch ();

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  // Predicted clock state and register copies
  logic [5:0] clock_sec     = SecondRst;
  logic [5:0] clock_min     = MinuteRst;
  logic [3:0] clock_hour    = HourRst;
  logic [6:0] clock_day     = DayRst;
  logic       clock_colon   = 1'b0;
  logic [7:0] window_pos    = 8'd0;
  logic [7:0] left_hits     = 8'd0;
  logic [7:0] center_hits   = 8'd0;
  logic [7:0] right_hits    = 8'd0;
  logic [7:0] cfg_window    = WindowLengthRst;
  logic [7:0] cfg_threshold = PressThresholdRst;

  thc_disp_t   pending_displays[$];
  thc_disp_t   expected_now;
  int unsigned sender_idle_pct = 0;
  int unsigned recv_idle_pct   = 0;
  int unsigned items_sent      = 0;
  int unsigned results_checked = 0;
  int unsigned reg_writes      = 0;
  int unsigned failures        = 0;
  int unsigned quiet_cycles    = 0;

  twelve_hour_clock_with_set_buttons i_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (cmd_ch),
    .out_o   (disp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  function automatic logic chance(input int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic thc_cmd_t make_item(input logic cmd, input logic l, input logic c,
                                         input logic r);
    thc_cmd_t it;
    it.command        = cmd;
    it.left_pressed   = l;
    it.center_pressed = c;
    it.right_pressed  = r;
    return it;
  endfunction

  function automatic int unsigned window_span();
    return (cfg_window == 8'd0) ? 1 : int'(cfg_window);
  endfunction

  // Advance the predicted clock by one item and queue the display it shows
  function automatic void predict_display(input thc_cmd_t it);
    thc_disp_t res;
    logic      closed;
    closed = 1'b0;
    if (it.command == CmdTick) begin
      clock_colon = ~clock_colon;
      clock_sec   = clock_sec + 6'd1;
      if (clock_sec > SecondMax) begin
        clock_sec = 6'd0;
        clock_min = clock_min + 6'd1;
      end
      if (clock_min > MinuteMax) begin
        clock_min  = 6'd0;
        clock_hour = clock_hour + 4'd1;
      end
      if (clock_hour > HourMax) begin
        clock_hour = HourMin;
        if (clock_day < DayMax) clock_day = clock_day + 7'd1;
      end
    end else begin
      if (it.left_pressed && left_hits != HitMax) left_hits = left_hits + 8'd1;
      if (it.center_pressed && center_hits != HitMax) center_hits = center_hits + 8'd1;
      if (it.right_pressed && right_hits != HitMax) right_hits = right_hits + 8'd1;
      if (int'(window_pos) + 1 < int'(cfg_window)) begin
        window_pos = window_pos + 8'd1;
      end else begin
        closed = 1'b1;
        if (left_hits > cfg_threshold)
          clock_day = (clock_day == 7'd0) ? DayMax : clock_day - 7'd1;
        if (right_hits > cfg_threshold)
          clock_min = (clock_min >= MinuteMax) ? 6'd0 : clock_min + 6'd1;
        if (center_hits > cfg_threshold)
          clock_hour = (clock_hour >= HourMax) ? HourMin : clock_hour + 4'd1;
        window_pos  = 8'd0;
        left_hits   = 8'd0;
        center_hits = 8'd0;
        right_hits  = 8'd0;
      end
    end
    res.hour_tens          = (clock_hour >= 4'd10);
    res.hour_ones          = 4'(int'(clock_hour) % 10);
    res.minute_tens        = 3'(int'(clock_min) / 10);
    res.minute_ones        = 4'(int'(clock_min) % 10);
    res.second_value       = clock_sec;
    res.day_tens           = 4'(int'(clock_day) / 10);
    res.day_ones           = 4'(int'(clock_day) % 10);
    res.colon_on           = clock_colon;
    res.hour_leading_blank = (clock_hour < 4'd10);
    res.window_done        = closed;
    pending_displays.push_back(res);
  endfunction

  function automatic string show_disp(input thc_disp_t d);
    return $sformatf("%0d%0d:%0d%0d:%0d day %0d%0d colon %0b blank %0b done %0b",
                     d.hour_tens, d.hour_ones, d.minute_tens, d.minute_ones,
                     d.second_value, d.day_tens, d.day_ones, d.colon_on,
                     d.hour_leading_blank, d.window_done);
  endfunction

  function automatic string differing_fields(input thc_disp_t a, input thc_disp_t b);
    string s;
    s = "";
    if (a.hour_tens !== b.hour_tens) s = {s, " hour_tens"};
    if (a.hour_ones !== b.hour_ones) s = {s, " hour_ones"};
    if (a.minute_tens !== b.minute_tens) s = {s, " minute_tens"};
    if (a.minute_ones !== b.minute_ones) s = {s, " minute_ones"};
    if (a.second_value !== b.second_value) s = {s, " second_value"};
    if (a.day_tens !== b.day_tens) s = {s, " day_tens"};
    if (a.day_ones !== b.day_ones) s = {s, " day_ones"};
    if (a.colon_on !== b.colon_on) s = {s, " colon_on"};
    if (a.hour_leading_blank !== b.hour_leading_blank) s = {s, " hour_leading_blank"};
    if (a.window_done !== b.window_done) s = {s, " window_done"};
    return s;
  endfunction

  task automatic log_failure(input string msg);
    failures++;
    if (failures <= ReportMax) $display("ERROR at %0t: %s", $time, msg);
  endtask

  // Send one item; valid stays high afterwards until the next call or a drain
  task automatic send_item(input thc_cmd_t it);
    while (chance(sender_idle_pct)) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid   <= 1'b1;
    cmd_ch.payload <= it;
    do @(posedge clk); while (!cmd_ch.ready);
    predict_display(it);
    items_sent++;
  endtask

  // Hold off the sender until every expected display item has come back
  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    while (pending_displays.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= CfgAddrW'({idx, 2'b00});
    pwdata  <= CfgDataW'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == RegWindowLength) begin
      cfg_window = value;
    end else begin
      cfg_threshold = value;
    end
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic configure(input logic [7:0] wl, input logic [7:0] thr);
    drain_results();
    write_reg(RegWindowLength, wl);
    write_reg(RegPressThreshold, thr);
  endtask

  // Ticks ignore the buttons; single-sample windows with a zero threshold
  // exercise each button action, a closing sample's own levels, zero length
  // and an unreachable threshold.
  task automatic test_directed();
    send_item(make_item(CmdTick, 1'b1, 1'b1, 1'b1));
    send_item(make_item(CmdTick, 1'b0, 1'b0, 1'b0));
    configure(8'd1, 8'd0);
    send_item(make_item(CmdSample, 1'b0, 1'b0, 1'b0));
    send_item(make_item(CmdSample, 1'b1, 1'b1, 1'b1));
    send_item(make_item(CmdSample, 1'b1, 1'b0, 1'b0));
    send_item(make_item(CmdSample, 1'b0, 1'b1, 1'b0));
    send_item(make_item(CmdSample, 1'b0, 1'b0, 1'b1));
    configure(8'd2, 8'd0);
    send_item(make_item(CmdSample, 1'b0, 1'b0, 1'b0));
    send_item(make_item(CmdSample, 1'b1, 1'b0, 1'b0));
    configure(8'd0, 8'd0);
    send_item(make_item(CmdSample, 1'b1, 1'b1, 1'b1));
    configure(8'd1, 8'd255);
    send_item(make_item(CmdSample, 1'b1, 1'b1, 1'b1));
  endtask

  // Shorten the window below the current sample index; the next sample closes it
  task automatic test_window_shrink();
    configure(8'd30, 8'd2);
    repeat (5) send_item(make_item(CmdSample, 1'b1, 1'b1, 1'b1));
    configure(8'd2, 8'd2);
    send_item(make_item(CmdSample, 1'b1, 1'b1, 1'b1));
    repeat (2) send_item(make_item(CmdSample, 1'b0, 1'b1, 1'b0));
  endtask

  // Set the time with the buttons close to a rollover, then tick across it
  task automatic test_set_and_rollover(input int unsigned rounds);
    int unsigned r;
    int unsigned hour_goal, minute_goal, day_goal;
    int unsigned hour_steps, minute_steps, day_steps;
    logic        l, c, m;
    configure(8'd1, 8'd0);
    for (r = 0; r < rounds; r++) begin
      hour_goal   = chance(70) ? 12 : $urandom_range(12, 1);
      minute_goal = chance(70) ? 59 : $urandom_range(59);
      case (r % 3)
        0:       day_goal = 0;
        1:       day_goal = 99;
        default: day_goal = $urandom_range(99);
      endcase
      hour_steps   = (hour_goal + 12 - clock_hour) % 12;
      minute_steps = (minute_goal + 60 - clock_min) % 60;
      day_steps    = (clock_day + 100 - day_goal) % 100;
      while (hour_steps + minute_steps + day_steps != 0) begin
        l = (day_steps != 0) && chance(75);
        c = (hour_steps != 0) && chance(75);
        m = (minute_steps != 0) && chance(75);
        if (l) day_steps--;
        if (c) hour_steps--;
        if (m) minute_steps--;
        send_item(make_item(CmdSample, l, c, m));
      end
      repeat (60 - int'(clock_sec) + $urandom_range(3))
        send_item(make_item(CmdTick, chance(50), chance(50), chance(50)));
    end
  endtask

  // Mostly whole windows with random press densities, runs of ticks, some noise
  task automatic test_random_traffic(input int unsigned upto);
    int unsigned bursts;
    int unsigned kind, n;
    int unsigned left_p, center_p, right_p;
    logic [7:0]  wl, thr;
    bursts = 0;
    while (items_sent < upto) begin
      if (bursts % 10 == 0) begin
        case ($urandom_range(19))
          0:         wl = 8'd0;
          1:         wl = 8'd255;
          2, 3, 4:   wl = 8'd1;
          default:   wl = 8'($urandom_range(12, 2));
        endcase
        case ($urandom_range(9))
          0:       thr = 8'd0;
          1:       thr = 8'd255;
          default: thr = 8'($urandom_range((wl == 8'd0) ? 1 : int'(wl)));
        endcase
        configure(wl, thr);
      end
      bursts++;
      kind = $urandom_range(99);
      if (kind < 30) begin
        repeat ($urandom_range(70, 1))
          send_item(make_item(CmdTick, chance(50), chance(50), chance(50)));
      end else if (kind < 85) begin
        left_p   = 25 * $urandom_range(4);
        center_p = 25 * $urandom_range(4);
        right_p  = 25 * $urandom_range(4);
        n = (int'(window_pos) < window_span()) ? window_span() - int'(window_pos) : 1;
        repeat (n)
          send_item(make_item(CmdSample, chance(left_p), chance(center_p), chance(right_p)));
      end else begin
        repeat ($urandom_range(10, 1))
          send_item(make_item(chance(50), chance(50), chance(50), chance(50)));
      end
    end
  endtask

  always @(posedge clk) begin
    disp_ch.ready <= !chance(recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && disp_ch.valid && disp_ch.ready) begin
      results_checked++;
      if (pending_displays.size() == 0) begin
        log_failure($sformatf("display item with nothing expected: %s",
                              show_disp(disp_ch.payload)));
      end else begin
        expected_now = pending_displays.pop_front();
        if (disp_ch.payload !== expected_now)
          log_failure($sformatf("mismatch in%s: expected %s, got %s",
                                differing_fields(expected_now, disp_ch.payload),
                                show_disp(expected_now), show_disp(disp_ch.payload)));
      end
    end
  end

  // End the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (disp_ch.valid && disp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    cmd_ch.valid   = 1'b0;
    cmd_ch.payload = '0;
    disp_ch.ready  = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    sender_idle_pct = 13;
    recv_idle_pct   = 53;
    test_directed();
    test_window_shrink();
    test_set_and_rollover(3);
    test_random_traffic(650);

    sender_idle_pct = 53;
    recv_idle_pct   = 13;
    test_set_and_rollover(4);
    test_random_traffic(1300);

    sender_idle_pct = 0;
    recv_idle_pct   = 0;
    test_set_and_rollover(3);
    test_random_traffic(1950);

    drain_results();
    $display("Run covered %0d ticks and button samples, %0d display items checked,",
             items_sent, results_checked);
    $display("%0d register writes and three idling patterns; %0d failures.",
             reg_writes, failures);
    if (failures == 0 && pending_displays.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/thc_pkg.sv
rtl/thc_cmd_if.sv
rtl/thc_disp_if.sv
rtl/thc_cfg.sv
rtl/thc_core.sv
rtl/twelve_hour_clock_with_set_buttons.sv
bench/tb.sv
